// ----- design/endpoint_address_table_macros.svh -----
// Assertion macros for the endpoint address table.
// Used by eat_ctrl, the module that carries the concurrent checks; no other dependencies.
`ifndef ENDPOINT_ADDRESS_TABLE_MACROS_SVH
`define ENDPOINT_ADDRESS_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/eat_pkg.sv -----
// Types and constants shared by the endpoint address table modules.
// No dependencies.
`default_nettype none

package eat_pkg;

  localparam int unsigned ENTRIES_DEF      = 1024;
  localparam int unsigned MAX_CTX_BITS_DEF = 16;
  localparam int unsigned HANDLE_W         = 64;
  localparam int unsigned CFG_W            = 5;

  localparam logic [HANDLE_W-1:0] NO_HANDLE = {HANDLE_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_LOOKUP  = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  typedef struct packed {
    logic [31:0] dev_addr;
    logic [31:0] cdm_id;
    logic [7:0]  ep_kind;
    logic [7:0]  rx_ctx_count;
    logic [23:0] cm_nic_id;
    logic [31:0] cookie;
    logic [15:0] mr_offset;
  } entry_t;

  typedef struct packed {
    logic entry_we;
    logic valid_we;
    logic valid_wd;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- design/eat_in_if.sv -----
// Input channel of the endpoint address table: one operation per beat.
// No dependencies.
`default_nettype none

interface eat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] handle;
  logic [31:0] dev_addr;
  logic [31:0] cdm_id;
  logic [7:0]  ep_kind;
  logic [31:0] cookie;
  logic [7:0]  rx_ctx_count;
  logic [23:0] cm_nic_id;
  logic [15:0] mr_offset;

  modport source (
    output valid, mode, handle, dev_addr, cdm_id, ep_kind, cookie,
           rx_ctx_count, cm_nic_id, mr_offset,
    input  ready
  );

  modport sink (
    input  valid, mode, handle, dev_addr, cdm_id, ep_kind, cookie,
           rx_ctx_count, cm_nic_id, mr_offset,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/eat_out_if.sv -----
// Result channel of the endpoint address table: one result per beat.
// No dependencies.
`default_nettype none

interface eat_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] result_handle;
  logic [31:0] out_dev_addr;
  logic [31:0] out_cdm_id;
  logic [7:0]  out_ep_kind;
  logic [31:0] out_cookie;
  logic [7:0]  out_rx_ctx_count;
  logic [23:0] out_cm_nic_id;
  logic [15:0] out_mr_offset;

  modport source (
    output valid, status, result_handle, out_dev_addr, out_cdm_id,
           out_ep_kind, out_cookie, out_rx_ctx_count, out_cm_nic_id,
           out_mr_offset,
    input  ready
  );

  modport sink (
    input  valid, status, result_handle, out_dev_addr, out_cdm_id,
           out_ep_kind, out_cookie, out_rx_ctx_count, out_cm_nic_id,
           out_mr_offset,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/endpoint_address_table.sv -----
// Endpoint address table. One beat is taken at a time, only in the idle state.
// Insert, remove and lookup read the entry at acceptance; the result is
// registered in the execute state once the result register is free. Reverse
// lookup scans one entry per cycle through the entry memory read port.
// Reset clears the fill count, the context register and the control state;
// the memories are not cleared, and entries past the fill count are never returned.
`default_nettype none

module endpoint_address_table import eat_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEF,
  parameter int unsigned MAX_CTX_BITS = MAX_CTX_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  eat_in_if.sink                in_i,
  eat_out_if.source             out_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             rd_valid;
  mem_ctl_t         mem_ctl;

  eat_ctrl #(
    .ENTRIES      (ENTRIES),
    .MAX_CTX_BITS (MAX_CTX_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .rd_addr_o   (rd_addr),
    .rd_entry_i  (rd_entry),
    .rd_valid_i  (rd_valid),
    .wr_addr_o   (wr_addr),
    .mem_ctl_o   (mem_ctl),
    .wr_entry_o  (wr_entry)
  );

  eat_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_addr_i  (wr_addr),
    .ctl_i      (mem_ctl),
    .wr_entry_i (wr_entry)
  );

endmodule

`default_nettype wire

// ----- design/eat_store.sv -----
// Entry memory and valid-mark memory of the endpoint address table.
// One write port and one registered read port each; uses eat_pkg.
`default_nettype none

module eat_store import eat_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output      entry_t           rd_entry_o,
  output      logic             rd_valid_o,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire mem_ctl_t         ctl_i,
  input  wire entry_t           wr_entry_i
);

  entry_t entry_mem_q [ENTRIES];
  logic   valid_mem_q [ENTRIES];
  entry_t rd_entry_q;
  logic   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.entry_we) begin
      entry_mem_q[wr_addr_i] <= wr_entry_i;
    end
    rd_entry_q <= entry_mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid_we) begin
      valid_mem_q[wr_addr_i] <= ctl_i.valid_wd;
    end
    rd_valid_q <= valid_mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

// ----- design/eat_ctrl.sv -----
// Sequencer of the endpoint address table: operation decode, fill count,
// context register, reverse scan and result register. Uses eat_pkg.
`default_nettype none

`include "endpoint_address_table_macros.svh"

module eat_ctrl import eat_pkg::*; #(
  parameter int unsigned ENTRIES      = ENTRIES_DEF,
  parameter int unsigned MAX_CTX_BITS = MAX_CTX_BITS_DEF,
  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  eat_in_if.sink                in_i,
  eat_out_if.source             out_o,
  output      logic [IDX_W-1:0] rd_addr_o,
  input  wire entry_t           rd_entry_i,
  input  wire logic             rd_valid_i,
  output      logic [IDX_W-1:0] wr_addr_o,
  output      mem_ctl_t         mem_ctl_o,
  output      entry_t           wr_entry_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CTX_W = $clog2(MAX_CTX_BITS + 1);
  localparam logic [6:0]  HANDLE_SH = 7'(HANDLE_W);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [CTX_W-1:0]  cfg_q, cfg_d;
  logic              out_valid_q, out_valid_d;

  mode_e             mode_q, mode_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  entry_t            item_q, item_d;

  status_e           st_q, st_d;
  logic [HANDLE_W-1:0] rh_q, rh_d;
  entry_t            res_q, res_d;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              done_scan;
  logic [6:0]        ctx_sh;
  logic [HANDLE_W-1:0] look_idx;
  logic [HANDLE_W-1:0] cnt_ext;
  logic              rem_ok;
  logic              look_ok;
  logic [31:0]       ctx;
  logic              full;
  logic              sep_bad;
  logic              scan_end;
  logic [CNT_W-1:0]  scan_nx;
  logic [31:0]       delta;
  logic              sep_hit;
  logic              ex_hit;
  logic              hit;
  logic [HANDLE_W-1:0] rev_handle;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Datapath terms evaluated against the registered operation.
  always_comb begin
    ctx_sh   = HANDLE_SH - 7'(cfg_q);
    look_idx = handle_q & ({HANDLE_W{1'b1}} >> cfg_q);
    cnt_ext  = HANDLE_W'(count_q);
    rem_ok   = (handle_q < cnt_ext) && rd_valid_i;
    look_ok  = (look_idx < cnt_ext) && rd_valid_i;
    ctx      = 32'(handle_q >> ctx_sh);
    full     = (count_q == CNT_W'(ENTRIES));
    sep_bad  = item_q.ep_kind[0] &&
               ({25'd0, item_q.rx_ctx_count} > (33'd1 << cfg_q));
    scan_end = (scan_q >= count_q);
    scan_nx  = scan_q + CNT_W'(1);
    delta    = item_q.cdm_id - rd_entry_i.cdm_id;
    sep_hit  = rd_entry_i.ep_kind[0] &&
               (rd_entry_i.dev_addr == item_q.dev_addr) &&
               (delta < {24'd0, rd_entry_i.rx_ctx_count});
    ex_hit   = !rd_entry_i.ep_kind[0] &&
               (rd_entry_i.dev_addr == item_q.dev_addr) &&
               (rd_entry_i.cdm_id == item_q.cdm_id);
    hit      = !scan_end && (sep_hit || ex_hit);
    if (sep_hit) begin
      rev_handle = HANDLE_W'(scan_q) | ({56'd0, delta[7:0]} << ctx_sh);
    end else begin
      rev_handle = HANDLE_W'(scan_q);
    end
    done_scan = scan_end || hit;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_e'(in_i.mode) == MODE_REVERSE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free && done_scan) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs, memory control and counters.
  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    out_load   = 1'b0;
    st_d       = ST_OK;
    rh_d       = NO_HANDLE;
    res_d      = '0;
    mem_ctl_o  = '0;
    wr_addr_o  = handle_q[IDX_W-1:0];
    wr_entry_o = item_q;
    rd_addr_o  = handle_q[IDX_W-1:0];
    count_d    = count_q;
    scan_d     = scan_q;

    unique case (state_q)
      S_IDLE: begin
        if (mode_e'(in_i.mode) == MODE_REVERSE) begin
          rd_addr_o = '0;
        end else begin
          rd_addr_o = in_i.handle[IDX_W-1:0];
        end
        if (accept) begin
          scan_d = '0;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (mode_q)
            MODE_INSERT: begin
              wr_addr_o = count_q[IDX_W-1:0];
              if (full) begin
                st_d = ST_FULL;
              end else if (sep_bad) begin
                st_d = ST_INVALID;
              end else begin
                rh_d               = HANDLE_W'(count_q);
                mem_ctl_o.entry_we = 1'b1;
                mem_ctl_o.valid_we = 1'b1;
                mem_ctl_o.valid_wd = 1'b1;
                count_d            = count_q + CNT_W'(1);
              end
            end
            MODE_REMOVE: begin
              if (!rem_ok) begin
                st_d = ST_INVALID;
              end else begin
                mem_ctl_o.valid_we = 1'b1;
                mem_ctl_o.valid_wd = 1'b0;
              end
            end
            MODE_LOOKUP: begin
              if (!look_ok) begin
                st_d = ST_INVALID;
              end else begin
                res_d        = rd_entry_i;
                res_d.cdm_id = rd_entry_i.cdm_id + ctx;
              end
            end
            MODE_REVERSE: begin
              st_d = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr_o = scan_q[IDX_W-1:0];
        if (done_scan) begin
          if (out_free) begin
            out_load = 1'b1;
            if (hit) begin
              rh_d = rev_handle;
            end else begin
              st_d = ST_NOT_FOUND;
            end
          end
        end else begin
          rd_addr_o = scan_nx[IDX_W-1:0];
          scan_d    = scan_nx;
        end
      end
      default: begin
        rd_addr_o = '0;
      end
    endcase
  end

  always_comb begin
    if (32'(cfg_wdata_i) > 32'(MAX_CTX_BITS)) begin
      cfg_d = CTX_W'(MAX_CTX_BITS);
    end else begin
      cfg_d = CTX_W'(cfg_wdata_i);
    end
    if (!cfg_we_i) begin
      cfg_d = cfg_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    mode_d   = accept ? mode_e'(in_i.mode) : mode_q;
    handle_d = accept ? in_i.handle : handle_q;
    if (accept) begin
      item_d.dev_addr     = in_i.dev_addr;
      item_d.cdm_id       = in_i.cdm_id;
      item_d.ep_kind      = in_i.ep_kind;
      item_d.rx_ctx_count = in_i.rx_ctx_count;
      item_d.cm_nic_id    = in_i.cm_nic_id;
      item_d.cookie       = in_i.cookie;
      item_d.mr_offset    = in_i.mr_offset;
    end else begin
      item_d = item_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    handle_q <= handle_d;
    item_q   <= item_d;
    if (out_load) begin
      st_q  <= st_d;
      rh_q  <= rh_d;
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = st_q;
  assign out_o.result_handle    = rh_q;
  assign out_o.out_dev_addr     = res_q.dev_addr;
  assign out_o.out_cdm_id       = res_q.cdm_id;
  assign out_o.out_ep_kind      = res_q.ep_kind;
  assign out_o.out_cookie       = res_q.cookie;
  assign out_o.out_rx_ctx_count = res_q.rx_ctx_count;
  assign out_o.out_cm_nic_id    = res_q.cm_nic_id;
  assign out_o.out_mr_offset    = res_q.mr_offset;

  `EAT_ASSERT_NXT(a_count_step, clk_i, rst_ni, mem_ctl_o.entry_we, count_q == $past(count_q) + CNT_W'(1), "fill count did not follow an entry write")
  `EAT_ASSERT_IMP(a_no_write_full, clk_i, rst_ni, mem_ctl_o.entry_we, count_q < CNT_W'(ENTRIES), "entry written while the table is full")
  `EAT_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, state_q == S_SCAN, scan_q <= count_q, "scan index past the fill count")
  `EAT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, state_q != S_IDLE, "accepted beat did not start an operation")
  `EAT_ASSERT_IMP(a_load_free, clk_i, rst_ni, out_load, out_free, "result register loaded while still occupied")

endmodule

`default_nettype wire

// ----- test/endpoint_address_table_test.sv -----
// Self-checking testbench for endpoint_address_table: random and directed table operations
// against an in-bench prediction of the table, with idle and stall phases on both channels.
// Depends on eat_pkg, eat_in_if, eat_out_if and the endpoint_address_table RTL.
`timescale 1ns / 100ps

module endpoint_address_table_test;
  import eat_pkg::*;

  localparam int unsigned TABLE_DEPTH = ENTRIES_DEF;
  localparam int unsigned CTX_LIMIT = MAX_CTX_BITS_DEF;
  localparam int unsigned PHASE_OPS = 70;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    mode_e               mode;
    logic [HANDLE_W-1:0] handle;
    entry_t              ent;
  } op_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] result_handle;
    entry_t              ent;
  } reply_t;

  typedef struct packed {
    op_t    op;
    reply_t reply;
  } beat_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  eat_in_if  in_ch ();
  eat_out_if out_ch ();

  endpoint_address_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  entry_t      entries [TABLE_DEPTH];
  bit          live [TABLE_DEPTH];
  int unsigned fill_count;
  int unsigned ctx_bits;
  logic [31:0] dev_pool [8];

  beat_t  ops_to_send [$];
  reply_t replies_due [$];
  beat_t  next_beat;
  reply_t beat_reply;
  reply_t due;
  bit     in_taken;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned ops_queued;
  int unsigned replies_checked;
  int unsigned fail_count;
  int unsigned settings_used;
  int unsigned ops_by_mode [4];
  int unsigned status_seen [4];
  longint unsigned cycle_count;

  function automatic reply_t address_table_op(op_t op);
    reply_t              r;
    logic [HANDLE_W-1:0] idx;
    logic [HANDLE_W-1:0] hd;
    logic [31:0]         ctx;
    logic [31:0]         delta;
    int unsigned         i;
    bit                  hit;
    r = '0;
    r.result_handle = NO_HANDLE;
    r.status = ST_OK;
    case (op.mode)
      MODE_INSERT: begin
        if (fill_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (op.ent.ep_kind[0] &&
                     32'(op.ent.rx_ctx_count) > (32'd1 << ctx_bits)) begin
          r.status = ST_INVALID;
        end else begin
          entries[fill_count] = op.ent;
          live[fill_count] = 1'b1;
          r.result_handle = HANDLE_W'(fill_count);
          fill_count++;
        end
      end
      MODE_REMOVE: begin
        r.status = ST_INVALID;
        if (op.handle < HANDLE_W'(fill_count)) begin
          if (live[int'(op.handle)]) begin
            live[int'(op.handle)] = 1'b0;
            r.status = ST_OK;
          end
        end
      end
      MODE_LOOKUP: begin
        idx = op.handle & ({HANDLE_W{1'b1}} >> ctx_bits);
        ctx = (ctx_bits == 0) ? 32'd0 : 32'(op.handle >> (HANDLE_W - ctx_bits));
        r.status = ST_INVALID;
        if (idx < HANDLE_W'(fill_count)) begin
          if (live[int'(idx)]) begin
            r.status = ST_OK;
            r.ent = entries[int'(idx)];
            r.ent.cdm_id = r.ent.cdm_id + ctx;
          end
        end
      end
      default: begin
        hit = 1'b0;
        for (i = 0; i < fill_count && !hit; i++) begin
          if (entries[i].ep_kind[0] && entries[i].dev_addr == op.ent.dev_addr) begin
            delta = op.ent.cdm_id - entries[i].cdm_id;
            if (delta < 32'(entries[i].rx_ctx_count)) begin
              hd = HANDLE_W'(i);
              if (ctx_bits != 0) begin
                hd = hd | (HANDLE_W'(delta) << (HANDLE_W - ctx_bits));
              end
              r.result_handle = hd;
              hit = 1'b1;
            end
          end else if (entries[i].dev_addr == op.ent.dev_addr &&
                       entries[i].cdm_id == op.ent.cdm_id) begin
            r.result_handle = HANDLE_W'(i);
            hit = 1'b1;
          end
        end
        r.status = hit ? ST_OK : ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  function automatic void queue_op(op_t op);
    beat_t b;
    b.op = op;
    b.reply = address_table_op(op);
    ops_to_send.push_back(b);
    ops_queued++;
    ops_by_mode[op.mode]++;
    status_seen[b.reply.status]++;
  endfunction

  function automatic op_t mk_op(mode_e m, logic [63:0] h, logic [31:0] dev,
                                logic [31:0] cdm, logic [7:0] nt, logic [7:0] rxc);
    op_t op;
    op = '0;
    op.mode = m;
    op.handle = h;
    op.ent.dev_addr = dev;
    op.ent.cdm_id = cdm;
    op.ent.ep_kind = nt;
    op.ent.rx_ctx_count = rxc;
    return op;
  endfunction

  function automatic op_t random_op(int unsigned insert_pct);
    op_t                 op;
    int unsigned         lim;
    int unsigned         variant;
    int unsigned         i;
    logic [HANDLE_W-1:0] base;
    op = '0;
    op.handle = {$urandom, $urandom};
    op.ent.dev_addr = ($urandom_range(3) != 0) ? dev_pool[$urandom_range(7)] : $urandom;
    op.ent.cdm_id = $urandom;
    op.ent.ep_kind = 8'($urandom);
    op.ent.rx_ctx_count = 8'($urandom);
    op.ent.cm_nic_id = 24'($urandom);
    op.ent.cookie = $urandom;
    op.ent.mr_offset = 16'($urandom);
    if ($urandom_range(99) < insert_pct) begin
      op.mode = MODE_INSERT;
      lim = (ctx_bits >= 8) ? 255 : (1 << ctx_bits);
      if (op.ent.ep_kind[0] && $urandom_range(9) != 0) begin
        op.ent.rx_ctx_count = 8'($urandom_range(lim));
      end
    end else begin
      variant = $urandom_range(9);
      case (variant)
        0: base = op.handle;
        1: base = HANDLE_W'(fill_count + $urandom_range(3));
        default: base = (fill_count == 0) ? '0 : HANDLE_W'($urandom_range(fill_count - 1));
      endcase
      case ($urandom_range(2))
        0: begin
          op.mode = MODE_REMOVE;
          op.handle = base;
        end
        1: begin
          op.mode = MODE_LOOKUP;
          op.handle = base;
          if (ctx_bits != 0 && variant != 0) begin
            op.handle = base | ({$urandom, $urandom} << (HANDLE_W - ctx_bits));
          end
        end
        default: begin
          op.mode = MODE_REVERSE;
          if (fill_count != 0 && $urandom_range(4) != 0) begin
            i = $urandom_range(fill_count - 1);
            op.ent.dev_addr = entries[i].dev_addr;
            op.ent.cdm_id = entries[i].cdm_id + (entries[i].ep_kind[0] ?
                            $urandom_range(entries[i].rx_ctx_count) : ($urandom_range(3) == 0));
          end
        end
      endcase
    end
    return op;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  function automatic void set_idling(int unsigned phase);
    case (phase)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
      default: begin src_idle_pct = 20; snk_stall_pct = 20; end
    endcase
  endfunction

  task automatic wait_idle();
    while (replies_checked != ops_queued) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_ctx(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    ctx_bits = (v > CTX_LIMIT) ? CTX_LIMIT : v;
    settings_used++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (!in_ch.valid || in_taken) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_beat = ops_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= next_beat.op.mode;
          in_ch.handle <= next_beat.op.handle;
          in_ch.dev_addr <= next_beat.op.ent.dev_addr;
          in_ch.cdm_id <= next_beat.op.ent.cdm_id;
          in_ch.ep_kind <= next_beat.op.ent.ep_kind;
          in_ch.cookie <= next_beat.op.ent.cookie;
          in_ch.rx_ctx_count <= next_beat.op.ent.rx_ctx_count;
          in_ch.cm_nic_id <= next_beat.op.ent.cm_nic_id;
          in_ch.mr_offset <= next_beat.op.ent.mr_offset;
          beat_reply <= next_beat.reply;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      replies_due.push_back(beat_reply);
    end
    if (out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 50) begin
          $error("result beat arrived with no operation outstanding");
        end
      end else begin
        due = replies_due.pop_front();
        check_field("status", 64'(due.status), 64'(out_ch.status));
        check_field("result_handle", due.result_handle, out_ch.result_handle);
        check_field("out_dev_addr", 64'(due.ent.dev_addr), 64'(out_ch.out_dev_addr));
        check_field("out_cdm_id", 64'(due.ent.cdm_id), 64'(out_ch.out_cdm_id));
        check_field("out_ep_kind", 64'(due.ent.ep_kind), 64'(out_ch.out_ep_kind));
        check_field("out_cookie", 64'(due.ent.cookie), 64'(out_ch.out_cookie));
        check_field("out_rx_ctx_count", 64'(due.ent.rx_ctx_count),
                    64'(out_ch.out_rx_ctx_count));
        check_field("out_cm_nic_id", 64'(due.ent.cm_nic_id), 64'(out_ch.out_cm_nic_id));
        check_field("out_mr_offset", 64'(due.ent.mr_offset), 64'(out_ch.out_mr_offset));
        replies_checked++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("endpoint_address_table regression: fail");
    $finish;
  end

  initial begin
    op_t         ones;
    int unsigned ctx_plan [8];
    int unsigned p;
    int unsigned k;
    ctx_plan = '{16, 31, 1, 8, 0, 17, 3, 12};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_INSERT;
    in_ch.handle = '0;
    in_ch.dev_addr = '0;
    in_ch.cdm_id = '0;
    in_ch.ep_kind = '0;
    in_ch.cookie = '0;
    in_ch.rx_ctx_count = '0;
    in_ch.cm_nic_id = '0;
    in_ch.mr_offset = '0;
    out_ch.ready = 1'b0;
    fill_count = 0;
    ctx_bits = 0;
    settings_used = 1;
    set_idling(0);
    foreach (dev_pool[d]) dev_pool[d] = $urandom;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_op(mk_op(MODE_REMOVE, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_LOOKUP, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_INSERT, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));
    ones = '1;
    ones.mode = MODE_INSERT;
    ones.ent.ep_kind = 8'hFE;
    queue_op(ones);
    queue_op(mk_op(MODE_INSERT, 64'd0, 32'h5E00, 32'hFFFF_FFFF, 8'h01, 8'd1));
    queue_op(mk_op(MODE_INSERT, 64'd0, 32'h5E00, 32'h20, 8'hFF, 8'd2));
    queue_op(mk_op(MODE_INSERT, 64'd0, 32'h5E00, 32'h10, 8'h01, 8'd0));
    queue_op(mk_op(MODE_LOOKUP, 64'd1, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_LOOKUP, NO_HANDLE, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'h5E00, 32'hFFFF_FFFF, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'h5E00, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'h5E00, 32'h10, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REMOVE, 64'd1, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REMOVE, 64'd1, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_LOOKUP, 64'd1, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REVERSE, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'd0));
    queue_op(mk_op(MODE_REMOVE, 64'h1_0000_0000, 32'd0, 32'd0, 8'h00, 8'd0));
    queue_op(mk_op(MODE_LOOKUP, 64'd0, 32'd0, 32'd0, 8'h00, 8'd0));

    for (p = 0; p < 8; p++) begin
      wait_idle();
      write_ctx(ctx_plan[p]);
      set_idling(p % 4);
      if (p == 0) begin
        queue_op(mk_op(MODE_LOOKUP, 64'hFFFF_0000_0000_0002, 32'd0, 32'd0, 8'h00, 8'd0));
      end
      for (k = 0; k < PHASE_OPS; k++) queue_op(random_op(35));
    end

    wait_idle();
    write_ctx(2);
    set_idling(3);
    while (fill_count < TABLE_DEPTH) queue_op(random_op(100));
    for (k = 0; k < 40; k++) queue_op(random_op(25));
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (replies_due.size() != 0) fail_count++;

    $display("Checked %0d operations (%0d inserts, %0d removes, %0d lookups, %0d reverse)",
             ops_queued, ops_by_mode[MODE_INSERT], ops_by_mode[MODE_REMOVE],
             ops_by_mode[MODE_LOOKUP], ops_by_mode[MODE_REVERSE]);
    $display("over %0d context widths: %0d ok, %0d invalid, %0d not found, %0d full, %0d used.",
             settings_used, status_seen[ST_OK], status_seen[ST_INVALID],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL], fill_count);
    if (fail_count == 0) begin
      $display("endpoint_address_table regression: pass");
    end else begin
      $display("endpoint_address_table regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/eat_pkg.sv
design/eat_in_if.sv
design/eat_out_if.sv
design/eat_store.sv
design/eat_ctrl.sv
design/endpoint_address_table.sv
test/endpoint_address_table_test.sv
